// ===== rtl/atl_pkg.sv =====
// Shared types, character codes and token descriptor for the assembler token lexer.
package atl_pkg;

  localparam int LEN_W = 7;
  localparam int POS_MAX_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [POS_MAX_W-1:0] pos_t;

  typedef enum logic [3:0] {
    KIND_COMMA   = 4'd0,
    KIND_NUMBER  = 4'd1,
    KIND_IDENT   = 4'd2,
    KIND_GLOBAL  = 4'd3,
    KIND_ADDRESS = 4'd4,
    KIND_LOCAL   = 4'd5,
    KIND_EOL     = 4'd6,
    KIND_EOF     = 4'd7,
    KIND_ERROR   = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_UNKNOWN    = 3'd1,
    ERR_NO_CLOSER  = 3'd2,
    ERR_BAD_OPENER = 3'd3,
    ERR_TOO_LONG   = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_COMMENT = 4'd1,
    MODE_OPEN    = 4'd2,
    MODE_NSIGN   = 4'd3,
    MODE_NZERO   = 4'd4,
    MODE_NDEC    = 4'd5,
    MODE_NHEX    = 4'd6,
    MODE_IBODY   = 4'd7,
    MODE_ISIGN   = 4'd8,
    MODE_ICLOSED = 4'd9,
    MODE_ADDR    = 4'd10,
    MODE_LOCAL   = 4'd11,
    MODE_EOL     = 4'd12,
    MODE_DEAD    = 4'd13
  } mode_t;

  typedef enum logic [1:0] {
    POS_START = 2'd0,
    POS_NEXT  = 2'd1,
    POS_CUR   = 2'd2
  } pos_sel_t;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  // One token's worth of output, handed from the front to the back.
  typedef struct packed {
    kind_t      kind;
    logic       buffered;
    logic       bank;
    len_t       len;
    logic [7:0] ch;
    logic       present;
    err_t       err;
    pos_t       line;
    pos_t       col;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_xdigit(logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_sign(logic [7:0] c);
    return c == CH_PLUS || c == CH_MINUS;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

endpackage

// ===== rtl/atl_char_if.sv =====
// Source character channel: one byte or an end-of-text mark per item.
interface atl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, text_char, end_of_text, input ready);
  modport sink (input valid, text_char, end_of_text, output ready);
endinterface

// ===== rtl/atl_token_if.sv =====
// Token result channel: one token character or marker item per handshake.
interface atl_token_if #(
  parameter int POS_W = 16
);
  logic             valid;
  logic             ready;
  logic [3:0]       token_kind;
  logic [7:0]       token_char;
  logic             char_present;
  logic             last_of_token;
  logic [POS_W-1:0] start_line;
  logic [POS_W-1:0] start_column;
  logic [2:0]       error_code;

  modport source (output valid, token_kind, token_char, char_present, last_of_token,
                  start_line, start_column, error_code, input ready);
  modport sink (input valid, token_kind, token_char, char_present, last_of_token,
                start_line, start_column, error_code, output ready);
endinterface

// ===== rtl/atl_front.sv =====
// Lexer front: accepts characters, tracks position, buffers token text, queues descriptors.
module atl_front #(
  parameter int TOKEN_CHARS = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  atl_char_if.sink                     text,
  input  logic [atl_pkg::QCNT_W-1:0]   q_count,
  input  atl_pkg::release_t            rel,
  output logic                         push0,
  output atl_pkg::desc_t               desc0,
  output logic                         push1,
  output atl_pkg::desc_t               desc1,
  output logic                         wr_en,
  output logic [$clog2(TOKEN_CHARS):0] wr_addr,
  output logic [7:0]                   wr_data
);

  localparam int IW = $clog2(TOKEN_CHARS);
  localparam int PW = POSITION_BITS;
  localparam logic [PW-1:0] MAXP = {PW{1'b1}};
  localparam logic [PW-1:0] ONE = PW'(1);

  atl_pkg::mode_t mode, mode_next;
  atl_pkg::len_t  len, len_next;
  logic [1:0]     op, op_next;
  logic [PW-1:0]  line, line_next, col, col_next;
  logic [PW-1:0]  sline, sline_next, scol, scol_next;
  logic           bank, bank_next;
  logic [1:0]     busy, busy_next;

  logic          acc;
  logic [7:0]    c;
  logic [PW-1:0] nl, nc;
  logic          full;
  logic [7:0]    closer;

  // Decoded action for the accepted item.
  logic              a_add, a_addsend, a_clr_op, a_send, a_disp, a_fail, a_eof;
  atl_pkg::mode_t    a_mode;
  atl_pkg::kind_t    a_kind;
  atl_pkg::err_t     a_err;
  atl_pkg::pos_sel_t a_fpos, a_epos;

  logic           first_v, second_v;
  atl_pkg::desc_t first_d, second_d;

  assign acc = text.valid && text.ready;
  assign text.ready = (q_count <= atl_pkg::QCNT_W'(atl_pkg::QUEUE_DEPTH - 2)) && !busy[~bank];
  assign c = text.text_char;
  assign full = len >= atl_pkg::LEN_W'(TOKEN_CHARS);
  assign closer = op[0] ? atl_pkg::CH_RPAREN : atl_pkg::CH_RBRACK;

  always_comb begin
    nl = line;
    nc = col;
    if (c == atl_pkg::CH_NL) begin
      if (line != MAXP) nl = line + ONE;
      nc = ONE;
    end else if (col != MAXP) begin
      nc = col + ONE;
    end
  end

  function automatic atl_pkg::desc_t mk(atl_pkg::kind_t k, logic buf_sel, logic bk,
                                        atl_pkg::len_t l, logic [7:0] ch, logic pr,
                                        atl_pkg::err_t e, logic [PW-1:0] ln,
                                        logic [PW-1:0] cl);
    atl_pkg::desc_t d;
    d.kind = k;
    d.buffered = buf_sel;
    d.bank = bk;
    d.len = l;
    d.ch = ch;
    d.present = pr;
    d.err = e;
    d.line = atl_pkg::pos_t'(ln);
    d.col = atl_pkg::pos_t'(cl);
    return d;
  endfunction

  // Decode: what the current mode does with this item.
  always_comb begin
    a_add = 1'b0;
    a_addsend = 1'b0;
    a_clr_op = 1'b0;
    a_send = 1'b0;
    a_disp = 1'b0;
    a_fail = 1'b0;
    a_eof = 1'b0;
    a_mode = mode;
    a_kind = atl_pkg::KIND_NUMBER;
    a_err = atl_pkg::ERR_NONE;
    a_fpos = atl_pkg::POS_CUR;
    a_epos = atl_pkg::POS_CUR;
    if (text.end_of_text) begin
      unique case (mode)
        atl_pkg::MODE_DEAD: ;
        atl_pkg::MODE_OPEN: begin
          a_fail = 1'b1;
          a_err = atl_pkg::ERR_BAD_OPENER;
          a_fpos = atl_pkg::POS_START;
        end
        atl_pkg::MODE_ISIGN, atl_pkg::MODE_ADDR: begin
          a_fail = 1'b1;
          a_err = atl_pkg::ERR_NO_CLOSER;
        end
        atl_pkg::MODE_IBODY: begin
          if (op != 2'b00) begin
            a_fail = 1'b1;
            a_err = atl_pkg::ERR_NO_CLOSER;
          end else begin
            a_send = 1'b1;
            a_kind = atl_pkg::KIND_IDENT;
            a_eof = 1'b1;
          end
        end
        atl_pkg::MODE_ICLOSED: begin
          a_send = 1'b1;
          a_kind = atl_pkg::KIND_IDENT;
          a_eof = 1'b1;
        end
        atl_pkg::MODE_NSIGN, atl_pkg::MODE_NZERO, atl_pkg::MODE_NDEC,
        atl_pkg::MODE_NHEX: begin
          a_send = 1'b1;
          a_eof = 1'b1;
        end
        atl_pkg::MODE_LOCAL: begin
          a_send = 1'b1;
          a_kind = atl_pkg::KIND_LOCAL;
          a_eof = 1'b1;
        end
        atl_pkg::MODE_EOL: begin
          a_eof = 1'b1;
          a_epos = atl_pkg::POS_START;
        end
        default: a_eof = 1'b1;
      endcase
    end else begin
      unique case (mode)
        atl_pkg::MODE_COMMENT: a_disp = (c == atl_pkg::CH_NL);
        atl_pkg::MODE_OPEN: begin
          if (atl_pkg::is_alpha(c)) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_IBODY;
          end else if (atl_pkg::is_digit(c) && op[0]) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_ADDR;
            a_clr_op = 1'b1;
          end else begin
            a_fail = 1'b1;
            a_err = atl_pkg::ERR_BAD_OPENER;
            a_fpos = atl_pkg::POS_START;
          end
        end
        atl_pkg::MODE_NSIGN, atl_pkg::MODE_NZERO: begin
          if (mode == atl_pkg::MODE_NSIGN && c == atl_pkg::CH_ZERO) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_NZERO;
          end else if (mode == atl_pkg::MODE_NZERO &&
                       (c == atl_pkg::CH_LOW_X || c == atl_pkg::CH_UP_X)) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_NHEX;
          end else if (atl_pkg::is_digit(c)) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_NDEC;
          end else begin
            a_send = 1'b1;
            a_disp = 1'b1;
          end
        end
        atl_pkg::MODE_NDEC: begin
          if (atl_pkg::is_digit(c)) a_add = 1'b1;
          else begin
            a_send = 1'b1;
            a_disp = 1'b1;
          end
        end
        atl_pkg::MODE_NHEX: begin
          if (atl_pkg::is_xdigit(c)) a_add = 1'b1;
          else begin
            a_send = 1'b1;
            a_disp = 1'b1;
          end
        end
        atl_pkg::MODE_IBODY: begin
          if (atl_pkg::is_alnum(c)) begin
            a_add = 1'b1;
          end else if (op == 2'b00) begin
            if (c == atl_pkg::CH_COLON) begin
              a_add = 1'b1;
              a_addsend = 1'b1;
              a_kind = atl_pkg::KIND_GLOBAL;
            end else begin
              a_send = 1'b1;
              a_kind = atl_pkg::KIND_IDENT;
              a_disp = 1'b1;
            end
          end else if (atl_pkg::is_sign(c)) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_ISIGN;
          end else if (c == closer) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_ICLOSED;
          end else begin
            a_fail = 1'b1;
            a_err = atl_pkg::ERR_NO_CLOSER;
            a_fpos = atl_pkg::POS_NEXT;
          end
        end
        atl_pkg::MODE_ISIGN: begin
          if (c == closer) begin
            a_add = 1'b1;
            a_mode = atl_pkg::MODE_ICLOSED;
          end else begin
            a_fail = 1'b1;
            a_err = atl_pkg::ERR_NO_CLOSER;
            a_fpos = atl_pkg::POS_NEXT;
          end
        end
        atl_pkg::MODE_ICLOSED: begin
          if (c == atl_pkg::CH_COLON) begin
            a_add = 1'b1;
            a_addsend = 1'b1;
            a_kind = atl_pkg::KIND_GLOBAL;
          end else begin
            a_send = 1'b1;
            a_kind = atl_pkg::KIND_IDENT;
            a_disp = 1'b1;
          end
        end
        atl_pkg::MODE_ADDR: begin
          if (atl_pkg::is_alnum(c)) begin
            a_add = 1'b1;
          end else if (c == atl_pkg::CH_RPAREN) begin
            a_add = 1'b1;
            a_addsend = 1'b1;
            a_kind = atl_pkg::KIND_ADDRESS;
          end else begin
            a_fail = 1'b1;
            a_err = atl_pkg::ERR_NO_CLOSER;
            a_fpos = atl_pkg::POS_NEXT;
          end
        end
        atl_pkg::MODE_LOCAL: begin
          if (atl_pkg::is_alnum(c)) a_add = 1'b1;
          else begin
            a_send = 1'b1;
            a_kind = atl_pkg::KIND_LOCAL;
            a_disp = 1'b1;
          end
        end
        atl_pkg::MODE_EOL: begin
          if (c != atl_pkg::CH_NL && !atl_pkg::is_blank(c)) begin
            a_send = 1'b1;
            a_kind = atl_pkg::KIND_EOL;
            a_disp = 1'b1;
          end
        end
        atl_pkg::MODE_DEAD: ;
        default: a_disp = 1'b1;
      endcase
    end
  end

  // Carry out the decoded action on the token state and build descriptors.
  always_comb begin
    mode_next = mode;
    len_next = len;
    op_next = op;
    line_next = line;
    col_next = col;
    sline_next = sline;
    scol_next = scol;
    bank_next = bank;
    first_v = 1'b0;
    second_v = 1'b0;
    first_d = '0;
    second_d = '0;
    wr_en = 1'b0;
    wr_addr = {bank, len[IW-1:0]};
    wr_data = c;
    if (acc) begin
      if (text.end_of_text) begin
        if (a_send) begin
          first_v = 1'b1;
          first_d = mk(a_kind, 1'b1, bank, len, 8'h00, 1'b1, atl_pkg::ERR_NONE, sline, scol);
          bank_next = ~bank;
        end
        if (a_fail) begin
          first_v = 1'b1;
          first_d = mk(atl_pkg::KIND_ERROR, 1'b0, bank, '0, 8'h00, 1'b0, a_err,
                       (a_fpos == atl_pkg::POS_START) ? sline : line,
                       (a_fpos == atl_pkg::POS_START) ? scol : col);
        end
        if (a_eof) begin
          second_v = 1'b1;
          second_d = mk(atl_pkg::KIND_EOF, 1'b0, bank, '0, 8'h00, 1'b0, atl_pkg::ERR_NONE,
                        (a_epos == atl_pkg::POS_START) ? sline : line,
                        (a_epos == atl_pkg::POS_START) ? scol : col);
        end
        mode_next = atl_pkg::MODE_IDLE;
        len_next = '0;
        op_next = 2'b00;
        line_next = ONE;
        col_next = ONE;
        sline_next = ONE;
        scol_next = ONE;
      end else begin
        line_next = nl;
        col_next = nc;
        if (a_add) begin
          if (full) begin
            first_v = 1'b1;
            first_d = mk(atl_pkg::KIND_ERROR, 1'b0, bank, '0, 8'h00, 1'b0,
                         atl_pkg::ERR_TOO_LONG, sline, scol);
            len_next = '0;
            op_next = 2'b00;
            mode_next = atl_pkg::MODE_DEAD;
          end else begin
            wr_en = 1'b1;
            len_next = len + atl_pkg::LEN_W'(1);
            mode_next = a_mode;
            if (a_clr_op) op_next = 2'b00;
            if (a_addsend) begin
              first_v = 1'b1;
              first_d = mk(a_kind, 1'b1, bank, len + atl_pkg::LEN_W'(1), 8'h00, 1'b1,
                           atl_pkg::ERR_NONE, sline, scol);
              bank_next = ~bank;
              len_next = '0;
              op_next = 2'b00;
              mode_next = atl_pkg::MODE_IDLE;
            end
          end
        end
        if (a_fail) begin
          first_v = 1'b1;
          first_d = mk(atl_pkg::KIND_ERROR, 1'b0, bank, '0, 8'h00, 1'b0, a_err,
                       (a_fpos == atl_pkg::POS_START) ? sline : nl,
                       (a_fpos == atl_pkg::POS_START) ? scol : nc);
          len_next = '0;
          op_next = 2'b00;
          mode_next = atl_pkg::MODE_DEAD;
        end
        if (a_send) begin
          first_v = 1'b1;
          if (a_kind == atl_pkg::KIND_EOL) begin
            first_d = mk(a_kind, 1'b0, bank, '0, 8'h00, 1'b0, atl_pkg::ERR_NONE,
                         sline, scol);
          end else begin
            first_d = mk(a_kind, 1'b1, bank, len, 8'h00, 1'b1, atl_pkg::ERR_NONE,
                         sline, scol);
            bank_next = ~bank;
          end
          len_next = '0;
          op_next = 2'b00;
          mode_next = atl_pkg::MODE_IDLE;
        end
        if (a_disp) begin
          mode_next = atl_pkg::MODE_IDLE;
          wr_addr = {bank_next, {IW{1'b0}}};
          if (atl_pkg::is_blank(c)) begin
            mode_next = atl_pkg::MODE_IDLE;
          end else if (c == atl_pkg::CH_SEMI) begin
            mode_next = atl_pkg::MODE_COMMENT;
          end else if (c == atl_pkg::CH_COMMA) begin
            second_v = 1'b1;
            second_d = mk(atl_pkg::KIND_COMMA, 1'b0, bank_next, '0, c, 1'b1,
                          atl_pkg::ERR_NONE, line, col);
            len_next = '0;
            op_next = 2'b00;
            sline_next = line;
            scol_next = col;
          end else if (c == atl_pkg::CH_NL) begin
            len_next = '0;
            op_next = 2'b00;
            sline_next = line;
            scol_next = col;
            mode_next = atl_pkg::MODE_EOL;
          end else if (c == atl_pkg::CH_LPAREN || c == atl_pkg::CH_LBRACK ||
                       atl_pkg::is_sign(c) || atl_pkg::is_digit(c) ||
                       atl_pkg::is_alpha(c) || c == atl_pkg::CH_DOT) begin
            wr_en = 1'b1;
            len_next = atl_pkg::LEN_W'(1);
            sline_next = line;
            scol_next = col;
            op_next = 2'b00;
            if (c == atl_pkg::CH_LPAREN) begin
              op_next = 2'b01;
              mode_next = atl_pkg::MODE_OPEN;
            end else if (c == atl_pkg::CH_LBRACK) begin
              op_next = 2'b10;
              mode_next = atl_pkg::MODE_OPEN;
            end else if (atl_pkg::is_sign(c)) begin
              mode_next = atl_pkg::MODE_NSIGN;
            end else if (c == atl_pkg::CH_ZERO) begin
              mode_next = atl_pkg::MODE_NZERO;
            end else if (atl_pkg::is_digit(c)) begin
              mode_next = atl_pkg::MODE_NDEC;
            end else if (atl_pkg::is_alpha(c)) begin
              mode_next = atl_pkg::MODE_IBODY;
            end else begin
              mode_next = atl_pkg::MODE_LOCAL;
            end
          end else begin
            second_v = 1'b1;
            second_d = mk(atl_pkg::KIND_ERROR, 1'b0, bank_next, '0, 8'h00, 1'b0,
                          atl_pkg::ERR_UNKNOWN, line, col);
            len_next = '0;
            op_next = 2'b00;
            mode_next = atl_pkg::MODE_DEAD;
          end
        end
      end
    end
  end

  assign push0 = first_v || second_v;
  assign desc0 = first_v ? first_d : second_d;
  assign push1 = first_v && second_v;
  assign desc1 = second_d;

  // A bank is owned by the back from the push of its text until its last character is read out.
  always_comb begin
    busy_next = busy;
    if (rel.valid) busy_next[rel.bank] = 1'b0;
    if (push0 && desc0.buffered) busy_next[bank] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= atl_pkg::MODE_IDLE;
      len <= '0;
      op <= 2'b00;
      line <= ONE;
      col <= ONE;
      sline <= ONE;
      scol <= ONE;
      bank <= 1'b0;
      busy <= 2'b00;
    end else begin
      mode <= mode_next;
      len <= len_next;
      op <= op_next;
      line <= line_next;
      col <= col_next;
      sline <= sline_next;
      scol <= scol_next;
      bank <= bank_next;
      busy <= busy_next;
    end
  end

endmodule

// ===== rtl/atl_queue.sv =====
// Descriptor queue between lexer front and emitter back; takes up to two items per cycle.
module atl_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push0,
  input  atl_pkg::desc_t             desc0,
  input  logic                       push1,
  input  atl_pkg::desc_t             desc1,
  input  logic                       pop,
  output logic                       head_valid,
  output atl_pkg::desc_t             head,
  output logic [atl_pkg::QCNT_W-1:0] count
);

  atl_pkg::desc_t entries [atl_pkg::QUEUE_DEPTH];
  logic [atl_pkg::QPTR_W-1:0] wp, rp;
  logic [atl_pkg::QCNT_W-1:0] npush;

  assign head_valid = count != '0;
  assign head = entries[rp];
  assign npush = atl_pkg::QCNT_W'(push0) + atl_pkg::QCNT_W'(push1);

  always_ff @(posedge clk) begin
    if (push0) entries[wp] <= desc0;
    if (push1) entries[wp + atl_pkg::QPTR_W'(1)] <= desc1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      wp <= wp + npush[atl_pkg::QPTR_W-1:0];
      if (pop) rp <= rp + atl_pkg::QPTR_W'(1);
      count <= count + npush - atl_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/atl_back.sv =====
// Lexer back: holds the two-bank text memory and sends each token out one item at a time.
module atl_back #(
  parameter int TOKEN_CHARS = 32,
  parameter int POSITION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         head_valid,
  input  atl_pkg::desc_t               head,
  output logic                         pop,
  input  logic                         wr_en,
  input  logic [$clog2(TOKEN_CHARS):0] wr_addr,
  input  logic [7:0]                   wr_data,
  output atl_pkg::release_t            rel,
  atl_token_if.source                  tokens
);

  localparam int IW = $clog2(TOKEN_CHARS);
  localparam int DEPTH = 2 * (1 << IW);

  logic [7:0] text_mem [DEPTH];

  logic           cur_valid;
  atl_pkg::desc_t cur;
  atl_pkg::len_t  idx;
  logic           advance, last, emit;

  logic           out_valid;
  atl_pkg::kind_t o_kind;
  logic [7:0]     o_inline, rd;
  logic           o_sel, o_present, o_last;
  atl_pkg::pos_t  o_line, o_col;
  atl_pkg::err_t  o_err;

  assign advance = !out_valid || tokens.ready;
  assign emit = advance && cur_valid;
  assign last = !cur.buffered || (idx + atl_pkg::LEN_W'(1) == cur.len);
  assign pop = !cur_valid && head_valid;
  assign rel.valid = emit && last && cur.buffered;
  assign rel.bank = cur.bank;

  always_ff @(posedge clk) begin
    if (wr_en) text_mem[wr_addr] <= wr_data;
    if (emit) rd <= text_mem[{cur.bank, idx[IW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (emit) begin
      o_kind <= cur.kind;
      o_inline <= cur.ch;
      o_sel <= cur.buffered;
      o_present <= cur.present;
      o_last <= last;
      o_line <= cur.line;
      o_col <= cur.col;
      o_err <= cur.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        idx <= '0;
      end else if (emit) begin
        if (last) cur_valid <= 1'b0;
        else idx <= idx + atl_pkg::LEN_W'(1);
      end
      if (advance) out_valid <= cur_valid;
    end
  end

  assign tokens.valid = out_valid;
  assign tokens.token_kind = o_kind;
  assign tokens.token_char = o_sel ? rd : o_inline;
  assign tokens.char_present = o_present;
  assign tokens.last_of_token = o_last;
  assign tokens.start_line = o_line[POSITION_BITS-1:0];
  assign tokens.start_column = o_col[POSITION_BITS-1:0];
  assign tokens.error_code = o_err;

endmodule

// ===== rtl/assembler_token_lexer.sv =====
// Top level of the assembler token lexer: front, descriptor queue and emitter back.
//
//   channel  | dir | payload                                      | accepted when
//   text     | in  | text_char, end_of_text                       | valid && ready
//   tokens   | out | kind, char, present, last, line, col, error  | valid && ready
//
// A finished token streams out through the queue entry, the current-descriptor register and
// the output register, then one character per cycle while the tokens channel is ready.
// Once a token's text is queued, the front takes no further item until that
// token's last character has been read out of its bank, or while the queue has fewer
// than two free entries.
// Synchronous reset returns to the idle state at line 1, column 1.
module assembler_token_lexer #(
  parameter int TOKEN_CHARS = 32,
  parameter int POSITION_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  atl_char_if.sink     text,
  atl_token_if.source  tokens
);

  localparam int AW = $clog2(TOKEN_CHARS) + 1;

  logic                       push0, push1, pop, head_valid, wr_en;
  atl_pkg::desc_t             desc0, desc1, head;
  logic [atl_pkg::QCNT_W-1:0] q_count;
  atl_pkg::release_t          rel;
  logic [AW-1:0]              wr_addr;
  logic [7:0]                 wr_data;

  atl_front #(.TOKEN_CHARS(TOKEN_CHARS), .POSITION_BITS(POSITION_BITS)) u_front (
    .clk(clk), .rst(rst), .text(text), .q_count(q_count), .rel(rel),
    .push0(push0), .desc0(desc0), .push1(push1), .desc1(desc1),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  atl_queue u_queue (
    .clk(clk), .rst(rst), .push0(push0), .desc0(desc0), .push1(push1), .desc1(desc1),
    .pop(pop), .head_valid(head_valid), .head(head), .count(q_count)
  );

  atl_back #(.TOKEN_CHARS(TOKEN_CHARS), .POSITION_BITS(POSITION_BITS)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head(head), .pop(pop),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .rel(rel), .tokens(tokens)
  );

endmodule
